>>> rtl/core/lcats_pkg.sv
// ----------------------------------------------------------------------------
// lcats_pkg
// Shared widths, reset values, codes and control types of the load-cell
// averaging, tare and scale core.
// ----------------------------------------------------------------------------
package lcats_pkg;

  localparam int RAW_W      = 24;
  localparam int ACC_W      = 32;
  localparam int AVG_W      = 24;
  localparam int WGT_W      = 32;
  localparam int CNT_W      = 8;
  localparam int OFS_W      = 24;
  localparam int CAL_W      = 24;
  localparam int TMO_W      = 16;
  localparam int ELAP_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int SAMPLE_BITS_DEF = 24;

  // shared serial divider: dividend |sum|, or |difference| scaled by 2^16
  localparam int DIV_FRAC_W = 16;
  localparam int DIV_D_W    = CAL_W;
  localparam int DIV_N_W    = OFS_W + 1 + DIV_FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);

  localparam logic [CNT_W-1:0]  AVG_COUNT_RST  = CNT_W'(1);
  localparam logic [OFS_W-1:0]  ZERO_OFS_RST   = OFS_W'(-17678);
  localparam logic [CAL_W-1:0]  CAL_FACTOR_RST = CAL_W'(57940);
  localparam logic              ALLOW_NEG_RST  = 1'b0;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST    = TMO_W'(1000);
  localparam logic [ELAP_W-1:0] ELAP_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVG_COUNT  = 3'd0,
    CFG_ZERO_OFS   = 3'd1,
    CFG_CAL_FACTOR = 3'd2,
    CFG_ALLOW_NEG  = 3'd3,
    CFG_TIMEOUT    = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    CMD_READING = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_W_START,
    ST_DIV_W,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic accept_sample;
    logic accept_tick;
    logic set_avg;
    logic start_w;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic count_hit;
    logic time_hit;
    logic div_busy;
  } dp_sts_t;

endpackage

>>> rtl/core/lcats_div.sv
// ----------------------------------------------------------------------------
// lcats_div
// Restoring serial divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcats_div import lcats_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               busy,
  output logic [DIV_N_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   dsr_r, dsr_nxt;
  logic [DIV_D_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[DIV_N_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
      end
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_D_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/lcats_dp.sv
// ----------------------------------------------------------------------------
// lcats_dp
// Datapath: configuration registers, accumulator, tick timer, average and
// weight arithmetic around the shared divider, result register.
// ----------------------------------------------------------------------------
module lcats_dp import lcats_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [RAW_W-1:0]      raw_reading,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic [AVG_W-1:0]      out_average,
  output logic [WGT_W-1:0]      out_weight,
  output logic                  out_timed_out
);

  localparam logic [DIV_N_W-1:0] AVG_POS_LIM = (DIV_N_W'(1) << (AVG_W - 1)) - DIV_N_W'(1);
  localparam logic [DIV_N_W-1:0] AVG_NEG_LIM = DIV_N_W'(1) << (AVG_W - 1);
  localparam logic [DIV_N_W-1:0] WGT_POS_LIM = (DIV_N_W'(1) << (WGT_W - 1)) - DIV_N_W'(1);
  localparam logic [DIV_N_W-1:0] WGT_NEG_LIM = DIV_N_W'(1) << (WGT_W - 1);
  localparam logic [AVG_W-1:0]   AVG_POS_SAT = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic [AVG_W-1:0]   AVG_NEG_SAT = {1'b1, {(AVG_W-1){1'b0}}};
  localparam logic [WGT_W-1:0]   WGT_POS_SAT = {1'b0, {(WGT_W-1){1'b1}}};
  localparam logic [WGT_W-1:0]   WGT_NEG_SAT = {1'b1, {(WGT_W-1){1'b0}}};

  logic [CNT_W-1:0]  avg_count_r;
  logic [OFS_W-1:0]  zero_ofs_r;
  logic [CAL_W-1:0]  cal_factor_r;
  logic              allow_neg_r;
  logic [TMO_W-1:0]  timeout_r;

  logic [ACC_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  samples_r, samples_inc;
  logic [ELAP_W-1:0] elapsed_r, elapsed_inc;

  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic              avg_neg_r;
  logic              tflag_r;
  logic              wneg_r;
  logic              wzero_r;

  logic [AVG_W-1:0]  out_average_r;
  logic [WGT_W-1:0]  out_weight_r;
  logic              out_timed_out_r;

  logic [ACC_W-1:0]  raw_ext, sample_ext, sum_mag;
  logic [CNT_W-1:0]  count_eff;
  logic              start_avg;

  logic signed [AVG_W-1:0] avg_s, zo_s, used_s;
  logic signed [AVG_W:0]   diff_s;
  logic [AVG_W:0]          diff_mag;
  logic [CAL_W-1:0]        cal_mag;
  logic [WGT_W-1:0]        weight_nxt;

  logic               div_start, div_busy;
  logic [DIV_N_W-1:0] div_dividend, quotient;
  logic [DIV_D_W-1:0] div_divisor;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_count_r  <= AVG_COUNT_RST;
      zero_ofs_r   <= ZERO_OFS_RST;
      cal_factor_r <= CAL_FACTOR_RST;
      allow_neg_r  <= ALLOW_NEG_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AVG_COUNT:  avg_count_r  <= cfg_wdata[CNT_W-1:0];
        CFG_ZERO_OFS:   zero_ofs_r   <= cfg_wdata[OFS_W-1:0];
        CFG_CAL_FACTOR: cal_factor_r <= cfg_wdata[CAL_W-1:0];
        CFG_ALLOW_NEG:  allow_neg_r  <= cfg_wdata[0];
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulation and timer
  assign raw_ext     = ACC_W'(raw_reading);
  assign sample_ext  = ACC_W'(signed'(raw_ext[SAMPLE_BITS-1:0]));
  assign sum_nxt     = sum_r + sample_ext;
  assign sum_mag     = sum_nxt[ACC_W-1] ? -sum_nxt : sum_nxt;
  assign samples_inc = samples_r + 1'b1;
  assign count_eff   = (avg_count_r == '0) ? CNT_W'(1) : avg_count_r;
  assign elapsed_inc = (elapsed_r == ELAP_MAX) ? ELAP_MAX : elapsed_r + 1'b1;

  assign sts.count_hit = (samples_inc == count_eff);
  assign sts.time_hit  = (elapsed_inc > ELAP_W'(timeout_r));
  assign sts.div_busy  = div_busy;

  assign start_avg = cmd.accept_sample && sts.count_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      samples_r <= '0;
      elapsed_r <= '0;
    end else if ((cmd.accept_sample && sts.count_hit) ||
                 (cmd.accept_tick && sts.time_hit)) begin
      sum_r     <= '0;
      samples_r <= '0;
      elapsed_r <= '0;
    end else if (cmd.accept_sample) begin
      sum_r     <= sum_nxt;
      samples_r <= samples_inc;
    end else if (cmd.accept_tick) begin
      elapsed_r <= elapsed_inc;
    end
  end

  // average from the first quotient, saturated to the field range
  always_comb begin
    if (avg_neg_r) begin
      avg_nxt = (quotient > AVG_NEG_LIM) ? AVG_NEG_SAT : -quotient[AVG_W-1:0];
    end else begin
      avg_nxt = (quotient > AVG_POS_LIM) ? AVG_POS_SAT : quotient[AVG_W-1:0];
    end
  end

  // tare clamp and difference
  assign avg_s    = avg_r;
  assign zo_s     = zero_ofs_r;
  assign used_s   = (!allow_neg_r && (avg_s < zo_s)) ? zo_s : avg_s;
  assign diff_s   = {used_s[AVG_W-1], used_s} - {zo_s[AVG_W-1], zo_s};
  assign diff_mag = diff_s[AVG_W] ? -diff_s : diff_s;
  assign cal_mag  = cal_factor_r[CAL_W-1] ? -cal_factor_r : cal_factor_r;

  // divider operands
  assign div_start    = start_avg || cmd.start_w;
  assign div_dividend = cmd.start_w ? {diff_mag, {DIV_FRAC_W{1'b0}}} : DIV_N_W'(sum_mag);
  assign div_divisor  = cmd.start_w ? cal_mag : DIV_D_W'(count_eff);

  lcats_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // weight from the second quotient, saturated
  always_comb begin
    if (wzero_r) begin
      weight_nxt = '0;
    end else if (wneg_r) begin
      weight_nxt = (quotient > WGT_NEG_LIM) ? WGT_NEG_SAT : -quotient[WGT_W-1:0];
    end else begin
      weight_nxt = (quotient > WGT_POS_LIM) ? WGT_POS_SAT : quotient[WGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start_avg) begin
      avg_neg_r <= sum_nxt[ACC_W-1];
      tflag_r   <= 1'b0;
    end
    if (cmd.accept_tick && sts.time_hit) begin
      avg_r   <= '0;
      tflag_r <= 1'b1;
    end else if (cmd.set_avg) begin
      avg_r <= avg_nxt;
    end
    if (cmd.start_w) begin
      wneg_r  <= diff_s[AVG_W] ^ cal_factor_r[CAL_W-1];
      wzero_r <= (diff_s == '0);
    end
    if (cmd.load_out) begin
      out_average_r   <= avg_r;
      out_weight_r    <= weight_nxt;
      out_timed_out_r <= tflag_r;
    end
  end

  assign out_average   = out_average_r;
  assign out_weight    = out_weight_r;
  assign out_timed_out = out_timed_out_r;

endmodule

>>> rtl/core/lcats_ctrl.sv
// ----------------------------------------------------------------------------
// lcats_ctrl
// Controller: input handshake, sequencing of both divisions, output valid.
// ----------------------------------------------------------------------------
module lcats_ctrl import lcats_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_TICK) begin
            cmd.accept_tick = 1'b1;
            if (sts.time_hit) begin
              st_nxt = ST_W_START;
            end
          end else begin
            cmd.accept_sample = 1'b1;
            if (sts.count_hit) begin
              st_nxt = ST_DIV_AVG;
            end
          end
        end
      end
      ST_DIV_AVG: begin
        if (!sts.div_busy) begin
          cmd.set_avg = 1'b1;
          st_nxt      = ST_W_START;
        end
      end
      ST_W_START: begin
        cmd.start_w = 1'b1;
        st_nxt      = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (!sts.div_busy) begin
          st_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/load_cell_average_tare_scale_core.sv
// ----------------------------------------------------------------------------
// load_cell_average_tare_scale_core
// Averages load-cell readings, applies tare and calibration, and gives a
// saturated Q16.16 weight; a tick timer gives up with a zero average.
//
//   beat     | ports                                    | handshake
//   ---------+------------------------------------------+------------
//   input    | in_cmd, in_raw_reading                   | valid/ready
//   result   | out_average, out_weight, out_timed_out   | valid/ready
//   config   | cfg_index, cfg_wdata                     | cfg_we only
//
// A reading or tick that gives no result is taken straight from idle.
// A reading that completes the count runs two passes of the shared
// 41-step serial divider (average, then weight) plus sequencing.
// A tick that times out runs one divider pass, for the weight.
// The result register lets the next beat in while a result waits.
// Reset is synchronous, active low; config and accumulator return to reset.
// ----------------------------------------------------------------------------
module load_cell_average_tare_scale_core import lcats_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [RAW_W-1:0]      in_raw_reading,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AVG_W-1:0]      out_average,
  output logic [WGT_W-1:0]      out_weight,
  output logic                  out_timed_out
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lcats_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcats_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .raw_reading   (in_raw_reading),
    .cmd           (cmd),
    .sts           (sts),
    .out_average   (out_average),
    .out_weight    (out_weight),
    .out_timed_out (out_timed_out)
  );

endmodule

>>> rtl/core/lcats_chk.sv
// ----------------------------------------------------------------------------
// lcats_chk
// Port-level checks of the load-cell core, bound to the top level.
// ----------------------------------------------------------------------------
module lcats_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_average,
  input logic [31:0] out_weight,
  input logic        out_timed_out
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_weight) && $stable(out_average))
    else $error("stalled result beat changed");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_average == 24'd0)
    else $error("timed-out result with non-zero average");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a new result only follows a computation that held the input off
  a_rise_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a computation");

endmodule

bind load_cell_average_tare_scale_core lcats_chk u_lcats_chk (.*);
